FILE: rtl/core/saxpy_pkg.sv
// Shared types, constants and binary32 helper functions for the AXPY stream.
// No dependencies; the multiplier, adder and top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package saxpy_pkg;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG   = 31'h7F80_0000;
  localparam logic signed [10:0] EXP_BIAS   = 11'sd127;
  localparam logic signed [10:0] MUL_POINT  = 11'sd46;
  localparam logic signed [10:0] ADD_POINT  = 11'sd61;
  localparam logic signed [10:0] EXP_MAX    = 11'sd255;

  // Request moved from the first half (multiply) to the second half (add).
  typedef struct packed {
    logic [31:0] prod;
    logic [31:0] y;
    logic        last;
  } mid_t;

  // Normalized significand with its lead bit at bit 30, and its exponent.
  typedef struct packed {
    logic signed [10:0] e;
    logic [30:0]        m;
  } norm_t;

  function automatic logic is_nan(input logic [31:0] v);
    return v[30:0] > INF_MAG;
  endfunction

  function automatic logic is_inf(input logic [31:0] v);
    return v[30:0] == INF_MAG;
  endfunction

  function automatic logic is_zero(input logic [31:0] v);
    return v[30:0] == 31'd0;
  endfunction

  // Returns {biased exponent, 24-bit significand}; subnormals get exponent 1.
  function automatic logic [31:0] unpack(input logic [31:0] v);
    if (v[30:23] == 8'd0) begin
      return {8'd1, 1'b0, v[22:0]};
    end
    return {v[30:23], 1'b1, v[22:0]};
  endfunction

  // Right shift that ORs every bit shifted out into bit 0.
  function automatic logic [63:0] shr_sticky(input logic [63:0] v, input logic [8:0] n);
    logic [63:0] mask;
    if (n >= 9'd64) begin
      return {63'd0, |v};
    end
    mask = (64'd1 << n) - 64'd1;
    return (v >> n) | {63'd0, |(v & mask)};
  endfunction

  // Moves the lead one of a nonzero value to bit 30 and adjusts the exponent.
  function automatic norm_t normalize(input logic [63:0] s, input logic signed [10:0] base);
    norm_t      r;
    logic [5:0] lead;
    lead = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (s[i]) begin
        lead = 6'(i);
      end
    end
    if (lead > 6'd30) begin
      r.m = 31'(shr_sticky(s, {3'd0, lead - 6'd30}));
    end else begin
      r.m = 31'(s << (6'd30 - lead));
    end
    r.e = base + $signed({5'd0, lead});
    return r;
  endfunction

  // Rounds to nearest even and packs, including subnormal and overflow cases.
  function automatic logic [31:0] round_pack(input logic sign, input logic signed [10:0] e,
                                             input logic [30:0] m);
    logic [63:0]        mm;
    logic [24:0]        q;
    logic [6:0]         rb;
    logic signed [10:0] ee;
    logic signed [10:0] sh;
    if (e >= EXP_MAX) begin
      return {sign, INF_MAG};
    end
    mm = {33'd0, m};
    ee = e;
    if (ee <= 11'sd0) begin
      sh = 11'sd1 - ee;
      mm = shr_sticky(mm, sh[8:0]);
      ee = 11'sd0;
    end
    rb = mm[6:0];
    q  = {1'b0, mm[30:7]};
    if (rb > 7'h40 || (rb == 7'h40 && q[0])) begin
      q = q + 25'd1;
    end
    if (q[24]) begin
      q  = q >> 1;
      ee = ee + 11'sd1;
    end
    if (ee == 11'sd0 && q[23]) begin
      ee = 11'sd1;
    end
    if (ee >= EXP_MAX) begin
      return {sign, INF_MAG};
    end
    return {sign, ee[7:0], q[22:0]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/saxpy_if.sv
// Valid/ready channel interfaces for the AXPY stream: input pairs, results
// and the scale-factor write port. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface saxpy_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_value;
  logic [31:0] y_value;
  logic        last_in;
  modport source (output valid, x_value, y_value, last_in, input ready);
  modport sink   (input valid, x_value, y_value, last_in, output ready);
endinterface

interface saxpy_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] y_result;
  logic        last_out;
  modport source (output valid, y_result, last_out, input ready);
  modport sink   (input valid, y_result, last_out, output ready);
endinterface

interface saxpy_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] scale_factor;
  modport source (output valid, scale_factor, input ready);
  modport sink   (input valid, scale_factor, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/saxpy_mul.sv
// Three-stage binary32 multiplier alpha*x: multiply, normalize, round.
// Depends on saxpy_pkg.
`timescale 1ns / 1ps
`default_nettype none

module saxpy_mul (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [31:0]        alpha,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [31:0]        x_value,
  input  wire logic [31:0]        y_value,
  input  wire logic               last_in,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      saxpy_pkg::mid_t    out_data
);
  import saxpy_pkg::*;

  logic        v1, v2, v3;
  logic        rdy1, rdy2, rdy3;

  // Stage 1 registers: raw product and classification.
  logic [47:0]        s1_prod;
  logic signed [10:0] s1_base;
  logic               s1_sign, s1_spec;
  logic [31:0]        s1_val, s1_y;
  logic               s1_last;
  // Stage 2 registers: normalized product.
  norm_t              s2_n;
  logic               s2_sign, s2_spec;
  logic [31:0]        s2_val, s2_y;
  logic               s2_last;

  logic [31:0] ua, ub;
  logic        sign;
  logic        spec_next;
  logic [31:0] val_next;

  // A stage takes a new request when it is empty or its content moves on.
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  // Special operands settle the product without arithmetic.
  always_comb begin
    ua        = unpack(alpha);
    ub        = unpack(x_value);
    sign      = alpha[31] ^ x_value[31];
    spec_next = 1'b1;
    val_next  = {sign, 31'd0};
    if (is_nan(alpha) || is_nan(x_value)) begin
      val_next = QNAN_BITS;
    end else if (is_inf(alpha) || is_inf(x_value)) begin
      val_next = (is_zero(alpha) || is_zero(x_value)) ? QNAN_BITS : {sign, INF_MAG};
    end else if (is_zero(alpha) || is_zero(x_value)) begin
      val_next = {sign, 31'd0};
    end else begin
      spec_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Datapath registers advance with their valid bits.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_prod <= ua[23:0] * ub[23:0];
      s1_base <= $signed({3'd0, ua[31:24]}) + $signed({3'd0, ub[31:24]}) - EXP_BIAS - MUL_POINT;
      s1_sign <= sign;
      s1_spec <= spec_next;
      s1_val  <= val_next;
      s1_y    <= y_value;
      s1_last <= last_in;
    end
    if (rdy2) begin
      s2_n    <= normalize({16'd0, s1_prod}, s1_base);
      s2_sign <= s1_sign;
      s2_spec <= s1_spec;
      s2_val  <= s1_val;
      s2_y    <= s1_y;
      s2_last <= s1_last;
    end
    if (rdy3) begin
      out_data.prod <= s2_spec ? s2_val : round_pack(s2_sign, s2_n.e, s2_n.m);
      out_data.y    <= s2_y;
      out_data.last <= s2_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/saxpy_add.sv
// Four-stage binary32 adder product+y: align, add, normalize, round.
// Depends on saxpy_pkg; the last stage is the block's output register.
`timescale 1ns / 1ps
`default_nettype none

module saxpy_add (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire saxpy_pkg::mid_t    in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [31:0]        y_result,
  output      logic               last_out
);
  import saxpy_pkg::*;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1: aligned operands.
  logic [63:0]        s1_sa, s1_sb;
  logic               s1_sub, s1_sign, s1_spec, s1_last;
  logic signed [10:0] s1_base;
  logic [31:0]        s1_val;
  // Stage 2: raw sum.
  logic [63:0]        s2_s;
  logic               s2_sign, s2_spec, s2_last;
  logic signed [10:0] s2_base;
  logic [31:0]        s2_val;
  // Stage 3: normalized sum.
  norm_t              s3_n;
  logic               s3_sign, s3_spec, s3_last;
  logic [31:0]        s3_val;

  logic [31:0] a, b, ua, ub;
  logic        spec_next;
  logic [31:0] val_next;
  logic [7:0]  dexp;
  logic [63:0] sum;
  logic [31:0] rnd;

  assign rdy4      = !v4 || out_ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v4;

  // Special operands, then order the two by magnitude for alignment.
  always_comb begin
    a         = in_data.prod;
    b         = in_data.y;
    spec_next = 1'b1;
    val_next  = 32'd0;
    if (is_nan(a) || is_nan(b)) begin
      val_next = QNAN_BITS;
    end else if (is_inf(a) && is_inf(b)) begin
      val_next = (a[31] ^ b[31]) ? QNAN_BITS : a;
    end else if (is_inf(a)) begin
      val_next = a;
    end else if (is_inf(b)) begin
      val_next = b;
    end else if (is_zero(a) && is_zero(b)) begin
      val_next = a & b;
    end else if (is_zero(a)) begin
      val_next = b;
    end else if (is_zero(b)) begin
      val_next = a;
    end else begin
      spec_next = 1'b0;
    end
    if (b[30:0] > a[30:0]) begin
      a = in_data.y;
      b = in_data.prod;
    end
    ua   = unpack(a);
    ub   = unpack(b);
    dexp = ua[31:24] - ub[31:24];
  end

  assign sum = s1_sub ? (s1_sa - s1_sb) : (s1_sa + s1_sb);
  assign rnd = s3_spec ? s3_val : round_pack(s3_sign, s3_n.e, s3_n.m);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_sa   <= {2'd0, ua[23:0], 38'd0};
      s1_sb   <= shr_sticky({2'd0, ub[23:0], 38'd0}, {1'b0, dexp});
      s1_sub  <= a[31] ^ b[31];
      s1_sign <= a[31];
      s1_base <= $signed({3'd0, ua[31:24]}) - ADD_POINT;
      s1_spec <= spec_next;
      s1_val  <= val_next;
      s1_last <= in_data.last;
    end
    // Exact cancellation gives +0.
    if (rdy2) begin
      s2_s    <= sum;
      s2_sign <= s1_sign;
      s2_base <= s1_base;
      s2_spec <= s1_spec || (sum == 64'd0);
      s2_val  <= s1_spec ? s1_val : 32'd0;
      s2_last <= s1_last;
    end
    if (rdy3) begin
      s3_n    <= normalize(s2_s, s2_base);
      s3_sign <= s2_sign;
      s3_spec <= s2_spec;
      s3_val  <= s2_val;
      s3_last <= s2_last;
    end
    // Any NaN leaves as the canonical quiet NaN.
    if (rdy4) begin
      y_result <= is_nan(rnd) ? QNAN_BITS : rnd;
      last_out <= s3_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/single_precision_axpy.sv
// Top level of the single-precision AXPY stream: scale register, multiplier
// and adder pipelines. Depends on saxpy_pkg, the channel interfaces, saxpy_mul, saxpy_add.
`timescale 1ns / 1ps
`default_nettype none

// For each request (x_value, y_value, last_in) the block returns
// y_result = alpha*x + y in binary32, with the product and the sum each
// rounded to nearest even, full subnormal support, and every NaN given as
// 0x7FC00000. last_out copies last_in. One request is taken per clock while
// the pipeline is not stalled. The seven register stages (three in the
// multiplier, four in the adder) lie between a request and its result.
// Backpressure stalls the stages one by one, so empty stages still fill
// while the output waits.
// Alpha is written through the cfg channel, which is always ready; write it
// only while no request is in flight.
module single_precision_axpy (
  input wire logic clk,
  input wire logic rst,
  saxpy_cfg_if.sink   cfg,
  saxpy_req_if.sink   req_in,
  saxpy_res_if.source res_out
);
  import saxpy_pkg::*;

  logic [31:0] alpha;
  logic        mid_valid, mid_ready;
  mid_t        mid_data;

  // Scale-factor register.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= 32'd0;
    end else if (cfg.valid) begin
      alpha <= cfg.scale_factor;
    end
  end

  saxpy_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .alpha     (alpha),
    .in_valid  (req_in.valid),
    .in_ready  (req_in.ready),
    .x_value   (req_in.x_value),
    .y_value   (req_in.y_value),
    .last_in   (req_in.last_in),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  saxpy_add u_add (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .y_result  (res_out.y_result),
    .last_out  (res_out.last_out)
  );

endmodule

`default_nettype wire

FILE: rtl/core/saxpy_chk.sv
// Port-level checks for single_precision_axpy and the bind that attaches them.
// Depends on the top level's channel ports only.
`timescale 1ns / 1ps
`default_nettype none

module saxpy_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] y_result
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(y_result)) else $error("result changed while stalled");

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result offered after reset");

  // Every NaN leaves in canonical form.
  a_nan_canon: assert property (@(posedge clk) disable iff (rst)
    out_valid && y_result[30:23] == 8'hFF && y_result[22:0] != 23'd0
    |-> y_result == 32'h7FC0_0000) else $error("non-canonical NaN");

  // The scale register accepts a write in any cycle out of reset.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready) else $error("scale write refused");

endmodule

bind single_precision_axpy saxpy_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .y_result  (res_out.y_result)
);

`default_nettype wire
